FILE: rtl/gyhh_pkg.sv
package gyhh_pkg;

   localparam logic [24:0] ONE_Q24 = 25'h100_0000;

   localparam logic [9:0]  TARGET_SPEED_RESET = 10'd0;
   localparam logic [15:0] DURATION_MS_RESET  = 16'd0;
   localparam logic [24:0] PROP_GAIN_RESET    = 25'd5033;
   localparam logic [24:0] DERIV_GAIN_RESET   = 25'd16777;
   localparam logic [24:0] SMOOTH_GAIN_RESET  = 25'd13421773;

   typedef enum logic [2:0] {
      REG_TARGET_SPEED = 3'd0,
      REG_DURATION_MS  = 3'd1,
      REG_PROP_GAIN    = 3'd2,
      REG_DERIV_GAIN   = 3'd3,
      REG_SMOOTH_GAIN  = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [9:0]  target_speed;
      logic [15:0] duration_ms;
      logic [24:0] prop_gain;
      logic [24:0] deriv_gain;
      logic [24:0] smooth_gain;
   } cfg_type;

   // error and error change of one tick, plus filtered speed in Q10.24
   typedef struct packed {
      logic               finished;
      logic signed [31:0] error;
      logic signed [32:0] delta;
      logic [33:0]        speed;
   } track_type;

   // gain products in Q.24
   typedef struct packed {
      logic               finished;
      logic signed [57:0] p_term;
      logic signed [58:0] d_term;
      logic [33:0]        speed;
   } prod_type;

endpackage

FILE: rtl/gyhh_csr.sv
module gyhh_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [2:0]           csr_index,
   input  logic [24:0]          csr_wdata,
   output gyhh_pkg::cfg_type    cfg,
   output logic                 state_clear
);

   gyhh_pkg::cfg_type       cfg_ff;
   gyhh_pkg::cfg_type       cfg_in;
   gyhh_pkg::reg_index_type index;

   assign index = gyhh_pkg::reg_index_type'(csr_index);

   always_comb begin
      cfg_in      = cfg_ff;
      state_clear = 1'b0;
      if (csr_write_en) begin
         unique case (index)
            gyhh_pkg::REG_TARGET_SPEED: begin
               cfg_in.target_speed = csr_wdata[9:0];
               state_clear         = 1'b1;
            end
            gyhh_pkg::REG_DURATION_MS: begin
               cfg_in.duration_ms = csr_wdata[15:0];
               state_clear        = 1'b1;
            end
            gyhh_pkg::REG_PROP_GAIN: begin
               cfg_in.prop_gain = csr_wdata;
               state_clear      = 1'b1;
            end
            gyhh_pkg::REG_DERIV_GAIN: begin
               cfg_in.deriv_gain = csr_wdata;
               state_clear       = 1'b1;
            end
            gyhh_pkg::REG_SMOOTH_GAIN: begin
               cfg_in.smooth_gain = csr_wdata;
               state_clear        = 1'b1;
            end
            // unknown index: drop the write, keep the state
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_speed <= gyhh_pkg::TARGET_SPEED_RESET;
         cfg_ff.duration_ms  <= gyhh_pkg::DURATION_MS_RESET;
         cfg_ff.prop_gain    <= gyhh_pkg::PROP_GAIN_RESET;
         cfg_ff.deriv_gain   <= gyhh_pkg::DERIV_GAIN_RESET;
         cfg_ff.smooth_gain  <= gyhh_pkg::SMOOTH_GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/gyhh_track.sv
module gyhh_track #(
   parameter int unsigned TICK_MS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gyhh_pkg::cfg_type     cfg,
   input  logic                  state_clear,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [15:0]    req_yaw_rate,
   output logic                  trk_valid,
   input  logic                  trk_ready,
   output gyhh_pkg::track_type   trk
);

   logic                 s0_valid_ff;
   logic signed [15:0]   yaw_ff;
   logic                 trk_valid_ff;
   gyhh_pkg::track_type  trk_ff;
   gyhh_pkg::track_type  trk_in;

   logic signed [31:0]   heading_ff;
   logic signed [31:0]   heading_in;
   logic signed [31:0]   last_error_ff;
   logic [33:0]          speed_ff;
   logic [33:0]          speed_in;
   logic [15:0]          elapsed_ff;
   logic [15:0]          elapsed_in;

   logic                 s0_ready;
   logic                 s1_ready;
   logic                 s1_load;
   logic                 running;
   logic signed [31:0]   error;
   logic signed [32:0]   delta;
   logic [24:0]          k;
   logic [24:0]          k_rest;
   logic [58:0]          k_prod;
   logic [34:0]          target_prod;
   logic [34:0]          speed_sum;
   logic [16:0]          elapsed_sum;

   assign s1_ready  = !trk_valid_ff || trk_ready;
   assign s0_ready  = !s0_valid_ff || s1_ready;
   assign s1_load   = s0_valid_ff && s1_ready;
   assign req_ready = s0_ready;

   assign running = (cfg.target_speed != '0) && (elapsed_ff < cfg.duration_ms);

   always_comb begin
      heading_in = heading_ff + {{16{yaw_ff[15]}}, yaw_ff};
      // negating the most negative heading saturates
      if (heading_in == 32'sh8000_0000) begin
         error = 32'sh7FFF_FFFF;
      end else begin
         error = -heading_in;
      end
      delta = {error[31], error} - {last_error_ff[31], last_error_ff};
   end

   // first-order filter: (k*s >> 24) + (1 - k) * target, k clamped to 1.0
   always_comb begin
      k           = (cfg.smooth_gain > gyhh_pkg::ONE_Q24) ? gyhh_pkg::ONE_Q24
                                                          : cfg.smooth_gain;
      k_rest      = gyhh_pkg::ONE_Q24 - k;
      k_prod      = 59'(k) * 59'(speed_ff);
      target_prod = 35'(k_rest) * 35'(cfg.target_speed);
      speed_sum   = k_prod[58:24] + target_prod;
      speed_in    = speed_sum[33:0];
   end

   always_comb begin
      elapsed_sum = {1'b0, elapsed_ff} + 17'(TICK_MS);
      elapsed_in  = elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];
   end

   always_comb begin
      trk_in.finished = !running;
      trk_in.error    = error;
      trk_in.delta    = delta;
      trk_in.speed    = speed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         trk_valid_ff <= 1'b0;
      end else begin
         if (s0_ready) begin
            s0_valid_ff <= req_valid;
         end
         if (s1_ready) begin
            trk_valid_ff <= s0_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s0_ready) begin
         yaw_ff <= req_yaw_rate;
      end
      if (s1_load) begin
         trk_ff <= trk_in;
      end
   end

   // loop state: advance only on a running tick
   always_ff @(posedge clock) begin
      if (reset || state_clear) begin
         heading_ff    <= '0;
         last_error_ff <= '0;
         speed_ff      <= '0;
         elapsed_ff    <= '0;
      end else if (s1_load && running) begin
         heading_ff    <= heading_in;
         last_error_ff <= error;
         speed_ff      <= speed_in;
         elapsed_ff    <= elapsed_in;
      end
   end

   assign trk_valid = trk_valid_ff;
   assign trk       = trk_ff;

`ifndef SYNTHESIS
   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      state_clear |=> (heading_ff == '0) && (last_error_ff == '0) &&
                      (speed_ff == '0) && (elapsed_ff == '0))
      else $error("loop state not cleared after register write");

   a_hold_between_items: assert property (@(posedge clock) disable iff (reset)
      (!s1_load && !state_clear) |=> $stable(heading_ff) && $stable(last_error_ff) &&
                                     $stable(speed_ff) && $stable(elapsed_ff))
      else $error("loop state moved without an item");

   a_finished_item: assert property (@(posedge clock) disable iff (reset)
      (s1_load && !running && !state_clear) |=> trk_valid_ff && trk_ff.finished &&
                                                $stable(heading_ff) && $stable(speed_ff))
      else $error("finished item changed loop state or lost its flag");
`endif

endmodule

FILE: rtl/gyhh_corr.sv
module gyhh_corr (
   input  logic                 clock,
   input  logic                 reset,
   input  gyhh_pkg::cfg_type    cfg,
   input  logic                 trk_valid,
   output logic                 trk_ready,
   input  gyhh_pkg::track_type  trk,
   output logic                 prd_valid,
   input  logic                 prd_ready,
   output gyhh_pkg::prod_type   prd
);

   logic                 prd_valid_ff;
   gyhh_pkg::prod_type   prd_ff;
   gyhh_pkg::prod_type   prd_in;
   logic signed [25:0]   prop_s;
   logic signed [25:0]   deriv_s;

   assign trk_ready = !prd_valid_ff || prd_ready;

   assign prop_s  = {1'b0, cfg.prop_gain};
   assign deriv_s = {1'b0, cfg.deriv_gain};

   always_comb begin
      prd_in.finished = trk.finished;
      prd_in.p_term   = prop_s * trk.error;
      prd_in.d_term   = deriv_s * trk.delta;
      prd_in.speed    = trk.speed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prd_valid_ff <= 1'b0;
      end else if (trk_ready) begin
         prd_valid_ff <= trk_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (trk_valid && trk_ready) begin
         prd_ff <= prd_in;
      end
   end

   assign prd_valid = prd_valid_ff;
   assign prd       = prd_ff;

endmodule

FILE: rtl/gyhh_out.sv
module gyhh_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                prd_valid,
   output logic                prd_ready,
   input  gyhh_pkg::prod_type  prd,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_left_drive,
   output logic signed [15:0]  rsp_right_drive,
   output logic                rsp_finished
);

   logic                rsp_valid_ff;
   logic signed [15:0]  left_ff;
   logic signed [15:0]  right_ff;
   logic                finished_ff;
   logic signed [15:0]  left_in;
   logic signed [15:0]  right_in;
   logic signed [59:0]  corr;
   logic signed [60:0]  speed_s;
   logic signed [60:0]  left_q24;
   logic signed [60:0]  right_q24;

   // truncate Q.24 toward zero, then clamp to 16 bits
   function automatic logic signed [15:0] drive_sat(input logic signed [60:0] q24);
      logic signed [36:0] whole;
      whole = 37'(q24 >>> 24);
      if (q24[60] && (q24[23:0] != '0)) begin
         whole = whole + 37'sd1;
      end
      if (whole > 37'sd32767) begin
         return 16'sh7FFF;
      end else if (whole < -37'sd32768) begin
         return 16'sh8000;
      end
      return whole[15:0];
   endfunction

   assign prd_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      corr      = 60'(prd.p_term) + 60'(prd.d_term);
      speed_s   = {27'b0, prd.speed};
      left_q24  = speed_s - 61'(corr);
      right_q24 = speed_s + 61'(corr);
      if (prd.finished) begin
         left_in  = '0;
         right_in = '0;
      end else begin
         left_in  = drive_sat(left_q24);
         right_in = drive_sat(right_q24);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (prd_ready) begin
         rsp_valid_ff <= prd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (prd_valid && prd_ready) begin
         left_ff     <= left_in;
         right_ff    <= right_in;
         finished_ff <= prd.finished;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_drive  = left_ff;
   assign rsp_right_drive = right_ff;
   assign rsp_finished    = finished_ff;

endmodule

FILE: rtl/gyro_heading_hold_drive_core.sv
// An accepted item passes in order through the input register, loop-state update,
// gain multiply and drive output register before its result is valid.
// Throughput: one item per cycle unless rsp_ready stalls the output; the heading
// and speed filter recurrences each close through a single register stage.
// Reset (synchronous): clears the loop state and the pipeline, loads register defaults.
// Every write to a known register index also clears the loop state.
module gyro_heading_hold_drive_core #(
   parameter int unsigned TICK_MS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [15:0]  req_yaw_rate,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_left_drive,
   output logic signed [15:0]  rsp_right_drive,
   output logic                rsp_finished,
   input  logic                csr_write_en,
   input  logic [2:0]          csr_index,
   input  logic [24:0]         csr_wdata
);

   gyhh_pkg::cfg_type    cfg;
   logic                 state_clear;
   logic                 trk_valid;
   logic                 trk_ready;
   gyhh_pkg::track_type  trk;
   logic                 prd_valid;
   logic                 prd_ready;
   gyhh_pkg::prod_type   prd;

   gyhh_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg),
      .state_clear  (state_clear)
   );

   gyhh_track #(
      .TICK_MS (TICK_MS)
   ) u_track (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .state_clear  (state_clear),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_yaw_rate (req_yaw_rate),
      .trk_valid    (trk_valid),
      .trk_ready    (trk_ready),
      .trk          (trk)
   );

   gyhh_corr u_corr (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .trk_valid (trk_valid),
      .trk_ready (trk_ready),
      .trk       (trk),
      .prd_valid (prd_valid),
      .prd_ready (prd_ready),
      .prd       (prd)
   );

   gyhh_out u_out (
      .clock           (clock),
      .reset           (reset),
      .prd_valid       (prd_valid),
      .prd_ready       (prd_ready),
      .prd             (prd),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_drive  (rsp_left_drive),
      .rsp_right_drive (rsp_right_drive),
      .rsp_finished    (rsp_finished)
   );

endmodule

FILE: tb/sv/tb_gyro_heading_hold_drive_core.sv
`timescale 1ns / 1ps

module tb_gyro_heading_hold_drive_core;

   localparam int TICK_MS = 10;
   localparam int LAST_REG = int'(gyhh_pkg::REG_SMOOTH_GAIN);
   localparam logic [24:0] GAIN_MAX = 25'h1FF_FFFF;
   localparam logic [9:0] TOP_SPEED = 10'h3FF;
   localparam logic [15:0] DURATION_MAX = 16'hFFFF;
   localparam logic signed [15:0] RATE_MAX = 16'sh7FFF;
   localparam logic signed [15:0] RATE_MIN = 16'sh8000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_TICKS = 1020;
   // closing run at full speed with the longest duration
   localparam int LONG_RUN_TICKS = 48;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic               done;
   } drive_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_yaw_rate = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_left_drive;
   logic signed [15:0] rsp_right_drive;
   logic rsp_finished;
   logic csr_write_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [24:0] csr_wdata = '0;

   // loop model: registers and state
   gyhh_pkg::cfg_type loop_cfg;
   logic signed [31:0] heading;
   logic signed [31:0] prev_error;
   logic [33:0] speed_q24;
   logic [15:0] elapsed;

   logic signed [15:0] yaw_ticks_q[$];
   drive_cmd_type drive_cmds_due[$];
   int mismatches = 0;

   bit tick_taken = 1'b0;
   int burst_left = 1;
   int gap_left = 0;
   logic [31:0] ready_mask = '1;
   logic [4:0] mask_pos = '0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   bit holding = 1'b0;

   gyro_heading_hold_drive_core #(
      .TICK_MS(TICK_MS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_yaw_rate   (req_yaw_rate),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_left_drive (rsp_left_drive),
      .rsp_right_drive(rsp_right_drive),
      .rsp_finished   (rsp_finished),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void clear_loop_state();
      heading = '0;
      prev_error = '0;
      speed_q24 = '0;
      elapsed = '0;
   endfunction

   function automatic logic signed [15:0] q24_to_drive(longint q);
      longint whole;
      whole = (q < 0) ? -((-q) >>> 24) : (q >>> 24);
      if (whole > 32767) whole = 32767;
      else if (whole < -32768) whole = -32768;
      return whole[15:0];
   endfunction

   // one tick of the heading-hold loop
   function automatic drive_cmd_type hold_heading_step(logic signed [15:0] rate);
      drive_cmd_type cmd;
      longint err;
      longint delta;
      longint corr;
      longint k;
      longint one;
      longint filt;
      longint speed;
      int unsigned next_ms;
      cmd = '0;
      if (loop_cfg.target_speed == 0 || elapsed >= loop_cfg.duration_ms) begin
         cmd.done = 1'b1;
         return cmd;
      end
      heading = heading + rate;
      err = -longint'(heading);
      if (err > 64'sd2147483647) err = 64'sd2147483647;
      delta = err - longint'(prev_error);
      corr = longint'(loop_cfg.prop_gain) * err + longint'(loop_cfg.deriv_gain) * delta;
      prev_error = err[31:0];
      one = longint'(gyhh_pkg::ONE_Q24);
      k = longint'(loop_cfg.smooth_gain);
      if (k > one) k = one;
      filt = (k * longint'(speed_q24) +
              (one - k) * (longint'(loop_cfg.target_speed) <<< 24)) >>> 24;
      speed_q24 = filt[33:0];
      next_ms = elapsed + TICK_MS;
      elapsed = (next_ms > 65535) ? 16'hFFFF : next_ms[15:0];
      speed = longint'(speed_q24);
      cmd.left = q24_to_drive(speed - corr);
      cmd.right = q24_to_drive(speed + corr);
      return cmd;
   endfunction

   // sender: bursts of items with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || tick_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (yaw_ticks_q.size() != 0) begin
            req_valid <= 1'b1;
            req_yaw_rate <= yaw_ticks_q.pop_front();
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 48);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall on a rotating mask, or hold off entirely
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !holding && ready_mask[mask_pos];
      end
      mask_pos = mask_pos + 1'b1;
   end

   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_OFF_CYCLES;
      end else if (hold_left > 0) begin
         hold_left--;
      end
      holding = (hold_left != 0);
   end

   always @(posedge clock) begin : watch
      drive_cmd_type want;
      drive_cmd_type got;
      got = '{left: rsp_left_drive, right: rsp_right_drive, done: rsp_finished};
      if (rsp_valid && rsp_ready) begin
         if (drive_cmds_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected drive item: left %0d right %0d finished %0b",
                        got.left, got.right, got.done);
         end else begin
            want = drive_cmds_due.pop_front();
            if (got.left !== want.left || got.right !== want.right ||
                got.done !== want.done) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("mismatch: want L %0d R %0d F %0b, got L %0d R %0d F %0b",
                           want.left, want.right, want.done, got.left, got.right, got.done);
            end
         end
      end
      tick_taken = req_valid && req_ready;
      if (tick_taken) drive_cmds_due.push_back(hold_heading_step(req_yaw_rate));
   end

   task automatic write_reg(logic [2:0] idx, logic [24:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         gyhh_pkg::REG_TARGET_SPEED: loop_cfg.target_speed = value[9:0];
         gyhh_pkg::REG_DURATION_MS:  loop_cfg.duration_ms = value[15:0];
         gyhh_pkg::REG_PROP_GAIN:    loop_cfg.prop_gain = value;
         gyhh_pkg::REG_DERIV_GAIN:   loop_cfg.deriv_gain = value;
         gyhh_pkg::REG_SMOOTH_GAIN:  loop_cfg.smooth_gain = value;
         default: begin
            // unused index: no effect, state kept
            @(posedge clock);
            #1;
            return;
         end
      endcase
      clear_loop_state();
      @(posedge clock);
      #1;
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (yaw_ticks_q.size() != 0 || req_valid || drive_cmds_due.size() != 0);
   endtask

   function automatic logic [24:0] pick_gain(logic [24:0] dflt);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return gyhh_pkg::ONE_Q24;
         2: return GAIN_MAX;
         3: return dflt;
         4: return 25'($urandom);
         5: return 25'($urandom_range(gyhh_pkg::ONE_Q24 - 4096, gyhh_pkg::ONE_Q24 + 4096));
         default: return 25'($urandom_range(0, 1 << 16));
      endcase
   endfunction

   function automatic logic [9:0] pick_speed();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 10'd1;
         2: return TOP_SPEED;
         default: return 10'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_duration(int unsigned count);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return DURATION_MAX;
         2: return 16'($urandom);
         default: return 16'($urandom_range(count * 5, count * 15));
      endcase
   endfunction

   function automatic logic signed [15:0] pick_rate(int spread);
      case ($urandom_range(0, 9))
         0, 1: return 16'($urandom);
         2: return ($urandom_range(0, 1) != 0) ? RATE_MAX : RATE_MIN;
         default: return 16'(int'($urandom_range(0, 2 * spread)) - spread);
      endcase
   endfunction

   function automatic logic [31:0] pick_ready_mask();
      case ($urandom_range(0, 3))
         0: return '1;
         1: return $urandom & $urandom | 32'h1;
         default: return $urandom | 32'h1;
      endcase
   endfunction

   task automatic shuffle_setup(int unsigned count);
      if ($urandom_range(0, 3) != 0)
         write_reg(gyhh_pkg::REG_TARGET_SPEED, 25'(pick_speed()));
      if ($urandom_range(0, 3) != 0)
         write_reg(gyhh_pkg::REG_DURATION_MS, 25'(pick_duration(count)));
      if ($urandom_range(0, 3) != 0)
         write_reg(gyhh_pkg::REG_PROP_GAIN, pick_gain(gyhh_pkg::PROP_GAIN_RESET));
      if ($urandom_range(0, 3) != 0)
         write_reg(gyhh_pkg::REG_DERIV_GAIN, pick_gain(gyhh_pkg::DERIV_GAIN_RESET));
      if ($urandom_range(0, 3) != 0)
         write_reg(gyhh_pkg::REG_SMOOTH_GAIN, pick_gain(gyhh_pkg::SMOOTH_GAIN_RESET));
      if ($urandom_range(0, 7) == 0)
         write_reg(3'(LAST_REG + $urandom_range(1, 3)), 25'($urandom));
   endtask

   initial begin : stimulus
      int ticks_sent;
      int phase_no;
      int count;
      int spread;
      ticks_sent = 0;
      phase_no = 0;
      loop_cfg = '{gyhh_pkg::TARGET_SPEED_RESET, gyhh_pkg::DURATION_MS_RESET,
                   gyhh_pkg::PROP_GAIN_RESET, gyhh_pkg::DERIV_GAIN_RESET,
                   gyhh_pkg::SMOOTH_GAIN_RESET};
      clear_loop_state();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // target speed zero after reset: stop at once
      yaw_ticks_q.push_back(RATE_MAX);
      yaw_ticks_q.push_back(RATE_MIN);
      wait_drained();

      // five running ticks at full speed and maximum gain, then finished
      write_reg(gyhh_pkg::REG_TARGET_SPEED, 25'(TOP_SPEED));
      write_reg(gyhh_pkg::REG_DURATION_MS, 25'd50);
      write_reg(gyhh_pkg::REG_PROP_GAIN, GAIN_MAX);
      write_reg(gyhh_pkg::REG_DERIV_GAIN, '0);
      write_reg(gyhh_pkg::REG_SMOOTH_GAIN, '0);
      yaw_ticks_q.push_back(RATE_MAX);
      yaw_ticks_q.push_back(RATE_MIN);
      yaw_ticks_q.push_back(-16'sd1);
      yaw_ticks_q.push_back(16'sd1);
      yaw_ticks_q.push_back(16'sd0);
      yaw_ticks_q.push_back(RATE_MAX);
      wait_drained();

      // unused index must not restart the manoeuvre
      write_reg(3'(LAST_REG + 1), GAIN_MAX);
      yaw_ticks_q.push_back(16'sd7);
      wait_drained();

      write_reg(gyhh_pkg::REG_DURATION_MS, 25'd1000);
      yaw_ticks_q.push_back(16'sd1000);
      yaw_ticks_q.push_back(-16'sd1);
      wait_drained();
      write_reg(3'(LAST_REG + 3), '0);
      yaw_ticks_q.push_back(16'sd500);
      yaw_ticks_q.push_back(16'sd0);
      wait_drained();

      // zero duration: finished on the first tick
      write_reg(gyhh_pkg::REG_DURATION_MS, '0);
      yaw_ticks_q.push_back(16'sd1);
      wait_drained();

      // smooth gain of exactly one and above one hold the speed
      write_reg(gyhh_pkg::REG_DURATION_MS, 25'd200);
      write_reg(gyhh_pkg::REG_TARGET_SPEED, 25'd1);
      write_reg(gyhh_pkg::REG_PROP_GAIN, '0);
      write_reg(gyhh_pkg::REG_DERIV_GAIN, GAIN_MAX);
      write_reg(gyhh_pkg::REG_SMOOTH_GAIN, gyhh_pkg::ONE_Q24);
      yaw_ticks_q.push_back(RATE_MIN);
      yaw_ticks_q.push_back(RATE_MAX);
      yaw_ticks_q.push_back(16'sd0);
      wait_drained();
      write_reg(gyhh_pkg::REG_SMOOTH_GAIN, GAIN_MAX);
      yaw_ticks_q.push_back(RATE_MAX);
      yaw_ticks_q.push_back(RATE_MAX);
      wait_drained();
      write_reg(gyhh_pkg::REG_PROP_GAIN, gyhh_pkg::ONE_Q24);
      write_reg(gyhh_pkg::REG_DERIV_GAIN, gyhh_pkg::ONE_Q24);
      write_reg(gyhh_pkg::REG_SMOOTH_GAIN, gyhh_pkg::SMOOTH_GAIN_RESET);
      write_reg(gyhh_pkg::REG_TARGET_SPEED, 25'd512);
      repeat (3) yaw_ticks_q.push_back(RATE_MIN);
      yaw_ticks_q.push_back(16'sd1234);
      wait_drained();

      while (ticks_sent < RANDOM_TICKS) begin
         count = $urandom_range(40, 160);
         shuffle_setup(count);
         case ($urandom_range(0, 3))
            0: spread = 4;
            1: spread = 64;
            2: spread = 1024;
            default: spread = 8000;
         endcase
         ready_mask = pick_ready_mask();
         for (int i = 0; i < count; i++) yaw_ticks_q.push_back(pick_rate(spread));
         // back-pressure: block the output while the sender keeps offering
         if (phase_no == 0) hold_request = 1'b1;
         wait_drained();
         ticks_sent += count;
         phase_no++;
      end

      // longest manoeuvre at full speed, output never stalled
      write_reg(gyhh_pkg::REG_TARGET_SPEED, 25'(TOP_SPEED));
      write_reg(gyhh_pkg::REG_DURATION_MS, 25'(DURATION_MAX));
      write_reg(gyhh_pkg::REG_PROP_GAIN, pick_gain(gyhh_pkg::PROP_GAIN_RESET));
      write_reg(gyhh_pkg::REG_DERIV_GAIN, pick_gain(gyhh_pkg::DERIV_GAIN_RESET));
      write_reg(gyhh_pkg::REG_SMOOTH_GAIN, gyhh_pkg::SMOOTH_GAIN_RESET);
      ready_mask = '1;
      for (int i = 0; i < LONG_RUN_TICKS; i++) yaw_ticks_q.push_back(pick_rate(64));
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && drive_cmds_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
